// ===== rtl/zsbp_pkg.sv =====
// Shared types and constants of the zero suppression bunch packer.
`timescale 1ns / 1ps

package zsbp_pkg;

  // Command codes carried by each input request
  typedef enum logic [1:0] {
    CMD_SAMPLE      = 2'd0,
    CMD_END_CHANNEL = 2'd1,
    CMD_FLUSH       = 2'd2
  } cmd_e;

  // Configuration register indexes
  localparam logic REG_THRESHOLD = 1'b0;

  localparam int unsigned WORD_BITS   = 10;
  localparam int unsigned CELL_BITS   = 32;
  localparam int unsigned BLOCK_WORDS = 16;
  localparam int unsigned BLOCK_CELLS = 5;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [WORD_BITS-1:0] PAD_WORD     = 10'h2AA;
  localparam logic [WORD_BITS-1:0] MAX_WORD     = 10'h3FF;
  localparam logic [3:0]           TRAILER_MARK = 4'hA;
  localparam logic [3:0]           LAST_FILL    = 4'd15;
  localparam logic [2:0]           LAST_CELL    = 3'd4;

  typedef logic [WORD_BITS-1:0] word_t;

  // One job: the ordered 10-bit words that one input request produces.
  // Order is data words, then pad words, then the trailer.
  typedef struct packed {
    logic [3:0]      n_words;    // total words, 1..15
    logic [1:0]      d_cnt;      // data words at the start, 0..2
    logic [3:0]      trl_start;  // position of the first trailer word
    word_t [1:0]     data;
    word_t [2:0]     trl;        // fourth trailer word is always the pad word
  } job_t;

  typedef logic [BLOCK_CELLS-1:0][CELL_BITS-1:0] block_t;
  typedef logic [BLOCK_WORDS-1:0][WORD_BITS-1:0] pack_t;

  // Clamp a 12-bit value into the 10-bit word range
  function automatic word_t sat10(input logic [11:0] v);
    word_t r;
    if (v > {2'b00, MAX_WORD}) begin
      r = MAX_WORD;
    end else begin
      r = v[WORD_BITS-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/zsbp_front.sv =====
// Front end: classifies each request and turns it into a job of 10-bit words.
`timescale 1ns / 1ps

module zsbp_front
  import zsbp_pkg::*;
#(
  parameter int unsigned MAX_TIME_BINS = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [1:0]  command_i,
  input  logic [11:0] adc_value_i,
  input  logic [11:0] hw_address_i,
  input  logic [11:0] threshold_i,
  output logic        job_valid_o,
  output job_t        job_o
);

  localparam int unsigned TW = $clog2(MAX_TIME_BINS + 1);
  localparam logic [TW-1:0] TIME_LIMIT = TW'(MAX_TIME_BINS);

  logic [TW-1:0] time_q, time_d;
  logic [TW-1:0] last_hit_q, last_hit_d;
  logic [TW-1:0] len_q, len_d;
  logic          open_q, open_d;
  logic [9:0]    wc_q, wc_d;
  logic          any_q, any_d;
  logic [3:0]    fill_q, fill_d;

  logic          in_range, hit, close_en, any_after;
  logic [9:0]    wc_close;
  logic [3:0]    fill_close, pad;
  logic [TW:0]   len_plus2;
  job_t          job;

  assign in_range  = (time_q < TIME_LIMIT);
  assign hit       = (adc_value_i >= threshold_i);
  assign len_plus2 = {1'b0, len_q} + (TW + 1)'(2);

  always_comb begin
    time_d     = time_q;
    last_hit_d = last_hit_q;
    len_d      = len_q;
    open_d     = open_q;
    wc_d       = wc_q;
    any_d      = any_q;
    close_en   = 1'b0;
    any_after  = any_q;
    wc_close   = wc_q;
    fill_close = fill_q;
    pad        = 4'd0;
    job        = '0;
    job.trl[0] = hw_address_i[9:0];

    case (cmd_e'(command_i))
      CMD_SAMPLE: begin
        if (in_range) begin
          time_d = time_q + TW'(1);
          if (hit) begin
            job.d_cnt   = 2'd1;
            job.data[0] = sat10(adc_value_i);
            last_hit_d  = time_q;
            open_d      = 1'b1;
            len_d       = len_q + TW'(1);
            wc_d        = wc_q + 10'd1;
            any_d       = 1'b1;
          end else if (open_q) begin
            close_en    = 1'b1;
            job.d_cnt   = 2'd2;
            job.data[0] = sat10(12'(last_hit_q));
            job.data[1] = sat10(12'(len_plus2));
            open_d      = 1'b0;
            len_d       = '0;
            wc_d        = wc_q + 10'd2;
            any_d       = 1'b1;
          end
        end
        job.n_words   = 4'(job.d_cnt);
        job.trl_start = 4'(job.d_cnt);
      end
      CMD_END_CHANNEL: begin
        // close the open bunch, then, if the channel had data, pad to a four-word boundary and add the trailer
        close_en = open_q;
        if (open_q) begin
          job.d_cnt   = 2'd2;
          job.data[0] = sat10(12'(last_hit_q));
          job.data[1] = sat10(12'(len_plus2));
        end
        any_after  = any_q | close_en;
        wc_close   = wc_q + (close_en ? 10'd2 : 10'd0);
        fill_close = fill_q + 4'(job.d_cnt);
        if (any_after) begin
          pad = {2'b00, 2'(4'd0 - fill_close)};
        end
        job.trl_start = 4'(job.d_cnt) + pad;
        job.n_words   = job.trl_start + (any_after ? 4'd4 : 4'd0);
        job.trl[1]    = {wc_close[3:0], TRAILER_MARK, hw_address_i[11:10]};
        job.trl[2]    = {TRAILER_MARK, wc_close[9:4]};
        time_d     = '0;
        last_hit_d = '0;
        open_d     = 1'b0;
        len_d      = '0;
        wc_d       = '0;
        any_d      = 1'b0;
      end
      CMD_FLUSH: begin
        // pad the partial block up to sixteen words
        job.n_words   = 4'd0 - fill_q;
        job.trl_start = job.n_words;
      end
      default: begin
        job.n_words = 4'd0;
      end
    endcase

    fill_d = fill_q + job.n_words;
  end

  assign job_valid_o = accept_i && (job.n_words != 4'd0);
  assign job_o       = job;

  // Advance channel state on each accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q     <= '0;
      last_hit_q <= '0;
      len_q      <= '0;
      open_q     <= 1'b0;
      wc_q       <= '0;
      any_q      <= 1'b0;
      fill_q     <= '0;
    end else if (accept_i) begin
      time_q     <= time_d;
      last_hit_q <= last_hit_d;
      len_q      <= len_d;
      open_q     <= open_d;
      wc_q       <= wc_d;
      any_q      <= any_d;
      fill_q     <= fill_d;
    end
  end

endmodule

// ===== rtl/zsbp_queue.sv =====
// Short job queue between the front end and the packer.
`timescale 1ns / 1ps

module zsbp_queue
  import zsbp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_en_i,
  input  job_t wr_job_i,
  output logic full_o,
  output logic rd_valid_o,
  output job_t rd_job_o,
  input  logic rd_pop_i
);

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);

  job_t [QUEUE_DEPTH-1:0] mem_q;
  logic [PW-1:0]          wr_ptr_q, rd_ptr_q;
  logic [PW:0]            count_q;
  logic                   do_wr, do_rd;

  assign full_o     = (count_q == (PW + 1)'(QUEUE_DEPTH));
  assign rd_valid_o = (count_q != '0);
  assign rd_job_o   = mem_q[rd_ptr_q];
  assign do_wr      = wr_en_i && !full_o;
  assign do_rd      = rd_pop_i && rd_valid_o;

  // Store incoming jobs
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_job_i;
    end
  end

  // Move pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= wr_ptr_q + PW'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= rd_ptr_q + PW'(1);
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + (PW + 1)'(1);
      end else if (!do_wr && do_rd) begin
        count_q <= count_q - (PW + 1)'(1);
      end
    end
  end

endmodule

// ===== rtl/zsbp_back.sv =====
// Back end: packs 10-bit words into 160-bit blocks and drains them as 32-bit words.
`timescale 1ns / 1ps

module zsbp_back
  import zsbp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        job_valid_i,
  input  job_t        job_i,
  output logic        job_pop_o,
  output logic        empty_o,
  input  logic        pop_i,
  output logic [31:0] out_word_o,
  output logic        last_of_block_o
);

  pack_t      pack_q;
  block_t     blk_q;
  logic       blk_valid_q;
  logic [2:0] idx_q;
  logic [3:0] fill_q;
  logic [3:0] step_q;

  logic       blk_free, adv, job_done, take;
  logic [3:0] trl_pos;
  word_t      word;

  // Pick the current word of the job at the queue head
  always_comb begin
    trl_pos = step_q - job_i.trl_start;
    if (step_q < 4'(job_i.d_cnt)) begin
      word = job_i.data[step_q[0]];
    end else if (step_q < job_i.trl_start) begin
      word = PAD_WORD;
    end else begin
      case (trl_pos[1:0])
        2'd0:    word = job_i.trl[0];
        2'd1:    word = job_i.trl[1];
        2'd2:    word = job_i.trl[2];
        default: word = PAD_WORD;
      endcase
    end
  end

  assign take      = pop_i && blk_valid_q;
  assign blk_free  = !blk_valid_q || (take && (idx_q == LAST_CELL));
  assign adv       = job_valid_i && ((fill_q != LAST_FILL) || blk_free);
  assign job_done  = (step_q == job_i.n_words - 4'd1);
  assign job_pop_o = adv && job_done;

  assign empty_o         = !blk_valid_q;
  assign out_word_o      = blk_q[idx_q];
  assign last_of_block_o = (idx_q == LAST_CELL);

  // Insert the word; hand a completed block to the output register
  always_ff @(posedge clk_i) begin
    if (adv) begin
      pack_q[fill_q] <= word;
      if (fill_q == LAST_FILL) begin
        blk_q <= block_t'({word, pack_q[BLOCK_WORDS-2:0]});
      end
    end
  end

  // Hold fill, job step and output drain state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      step_q      <= '0;
      blk_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (adv) begin
        fill_q <= fill_q + 4'd1;
        step_q <= job_done ? 4'd0 : step_q + 4'd1;
      end
      if (adv && (fill_q == LAST_FILL)) begin
        blk_valid_q <= 1'b1;
        idx_q       <= '0;
      end else if (take) begin
        if (idx_q == LAST_CELL) begin
          blk_valid_q <= 1'b0;
          idx_q       <= '0;
        end else begin
          idx_q <= idx_q + 3'd1;
        end
      end
    end
  end

endmodule

// ===== rtl/zero_suppress_bunch_packer.sv =====
// Top level of the zero suppression bunch packer.
//
//   channel   direction  handshake                 payload
//   input     in         push / full               command_i, adc_value_i, hw_address_i
//   result    out        empty / pop               out_word_o, last_of_block_o
//   config    in         psel penable pwrite ...   threshold at byte address 0
//
// The front end takes one request per clock whenever the four-entry job queue has room.
// The packer inserts one 10-bit word per clock while it is not stalled, and a request
// yields 0 to 15 words (a sample 0 to 2, end of channel up to 9, flush up to 15).
// A finished block drains in five pops; the packer stalls only when a new block
// completes while the previous one still has words waiting. Reset needs no clearing pass.
`timescale 1ns / 1ps

module zero_suppress_bunch_packer
  import zsbp_pkg::*;
#(
  parameter int unsigned MAX_TIME_BINS = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  command_i,
  input  logic [11:0] adc_value_i,
  input  logic [11:0] hw_address_i,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] out_word_o,
  output logic        last_of_block_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [11:0] threshold_q;
  logic        accept, job_valid, q_valid, q_pop;
  job_t        job, q_job;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_THRESHOLD) ? {20'd0, threshold_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= '0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_THRESHOLD)) begin
      threshold_q <= pwdata[11:0];
    end
  end

  assign accept = push && !full;

  zsbp_front #(
    .MAX_TIME_BINS(MAX_TIME_BINS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .command_i    (command_i),
    .adc_value_i  (adc_value_i),
    .hw_address_i (hw_address_i),
    .threshold_i  (threshold_q),
    .job_valid_o  (job_valid),
    .job_o        (job)
  );

  zsbp_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (job_valid),
    .wr_job_i   (job),
    .full_o     (full),
    .rd_valid_o (q_valid),
    .rd_job_o   (q_job),
    .rd_pop_i   (q_pop)
  );

  zsbp_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .job_valid_i     (q_valid),
    .job_i           (q_job),
    .job_pop_o       (q_pop),
    .empty_o         (empty),
    .pop_i           (pop),
    .out_word_o      (out_word_o),
    .last_of_block_o (last_of_block_o)
  );

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the zero suppression bunch packer.
`timescale 1ns / 1ps

module tb
  import zsbp_pkg::*;
();

  localparam int unsigned CLK_PERIOD     = 12;
  localparam int unsigned TIME_BINS      = 1024;
  localparam int unsigned SETTLE_CYCLES  = 80;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned PHASE_ITEMS    = 46;

  // Command code that the block must ignore
  localparam logic [1:0] CMD_UNUSED     = 2'd3;
  localparam logic [2:0] THRESHOLD_ADDR = {REG_THRESHOLD, 2'b00};

  typedef struct {
    logic [31:0] word;
    logic        last;
  } block_word_t;

  // Track the channel and block state, and hold the block words still owed
  class block_word_tracker;
    logic [11:0] thresh;
    pack_t       words;
    logic [4:0]  fill;
    logic [10:0] time_bin;
    logic [10:0] hit_bin;
    logic [10:0] run_len;
    logic        bunch_on;
    logic        has_data;
    logic [9:0]  data_total;
    block_word_t pending_words[$];
    int unsigned mismatches;

    function new();
      thresh     = '0;
      words      = '0;
      fill       = '0;
      time_bin   = '0;
      hit_bin    = '0;
      run_len    = '0;
      bunch_on   = 1'b0;
      has_data   = 1'b0;
      data_total = '0;
      mismatches = 0;
    endfunction

    // Insert one 10-bit word; release the five cells once the block is full
    function void append_word(word_t w);
      block_t cells;
      words[fill] = w;
      fill++;
      if (fill == BLOCK_WORDS) begin
        cells = block_t'(words);
        for (int k = 0; k < BLOCK_CELLS; k++) begin
          pending_words.push_back('{cells[k], logic'(k == BLOCK_CELLS - 1)});
        end
        words = '0;
        fill  = '0;
      end
    endfunction

    // Clamp to the word range and count it as channel data
    function void append_data(int unsigned v);
      append_word((v > 32'h3FF) ? MAX_WORD : word_t'(v));
      data_total++;
      has_data = 1'b1;
    endfunction

    function void close_bunch();
      if (bunch_on) begin
        append_data(hit_bin);
        append_data(run_len + 32'd2);
        bunch_on = 1'b0;
        run_len  = '0;
      end
    endfunction

    // Work out the block words caused by one accepted request
    function void take_request(logic [1:0] cmd, logic [11:0] adc, logic [11:0] hw);
      int unsigned pad;
      case (cmd)
        CMD_SAMPLE: begin
          if (time_bin < TIME_BINS) begin
            if (adc >= thresh) begin
              append_data(adc);
              hit_bin  = time_bin;
              bunch_on = 1'b1;
              if (run_len < 11'h7FF) run_len++;
            end else begin
              close_bunch();
            end
            time_bin++;
          end
        end
        CMD_END_CHANNEL: begin
          close_bunch();
          if (has_data) begin
            pad = (BLOCK_WORDS - fill) % 4;
            repeat (pad) append_word(PAD_WORD);
            append_word(hw[9:0]);
            append_word({data_total[3:0], TRAILER_MARK, hw[11:10]});
            append_word({TRAILER_MARK, data_total[9:4]});
            append_word(PAD_WORD);
          end
          time_bin   = '0;
          hit_bin    = '0;
          bunch_on   = 1'b0;
          run_len    = '0;
          data_total = '0;
          has_data   = 1'b0;
        end
        CMD_FLUSH: begin
          while (fill != 0) append_word(PAD_WORD);
        end
        default: begin
        end
      endcase
    endfunction

    function void check_word(logic [31:0] got_word, logic got_last);
      block_word_t want;
      if (pending_words.size() == 0) begin
        $error("unexpected output word %h", got_word);
        mismatches++;
        return;
      end
      want = pending_words.pop_front();
      if (got_word !== want.word) begin
        $error("out_word: expected %h, got %h", want.word, got_word);
        mismatches++;
      end
      if (got_last !== want.last) begin
        $error("last_of_block: expected %b, got %b", want.last, got_last);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic [1:0]  command_i;
  logic [11:0] adc_value_i;
  logic [11:0] hw_address_i;
  logic        empty;
  logic        pop = 1'b0;
  logic [31:0] out_word_o;
  logic        last_of_block_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  block_word_tracker sb;
  int unsigned src_gap_pct;
  int unsigned sink_stall_pct;
  int unsigned stall_left = 0;
  int unsigned idle_cycles = 0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  zero_suppress_bunch_packer #(
    .MAX_TIME_BINS(TIME_BINS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .command_i      (command_i),
    .adc_value_i    (adc_value_i),
    .hw_address_i   (hw_address_i),
    .empty          (empty),
    .pop            (pop),
    .out_word_o     (out_word_o),
    .last_of_block_o(last_of_block_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // Stall the result side in random bursts
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      pop = 1'b0;
      stall_left--;
    end else if (sink_stall_pct != 0 && $urandom_range(0, 99) < sink_stall_pct) begin
      pop = 1'b0;
      stall_left = $urandom_range(0, 9);
    end else begin
      pop = 1'b1;
    end
  end

  // Check every popped word
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) sb.check_word(out_word_o, last_of_block_o);
  end

  // Abort when nothing moves for too long
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $error("no request or result moved for %0d cycles", WATCHDOG_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one request after an optional gap; hold it until accepted
  task automatic send_request(logic [1:0] cmd, logic [11:0] adc, logic [11:0] hw);
    int unsigned gap;
    @(negedge clk_i);
    if (src_gap_pct != 0 && $urandom_range(0, 99) < src_gap_pct) begin
      gap  = $urandom_range(1, 10);
      push = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push         = 1'b1;
    command_i    = cmd;
    adc_value_i  = adc;
    hw_address_i = hw;
    do @(posedge clk_i); while (full);
    sb.take_request(cmd, adc, hw);
  endtask

  // Drop push, drain every owed word, then let the job queue empty out
  task automatic wait_for_quiet();
    @(negedge clk_i);
    push = 1'b0;
    while (sb.pending_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write the threshold, then read it back
  task automatic write_threshold(logic [11:0] value);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = THRESHOLD_ADDR;
    pwdata  = 32'(value);
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.thresh = value;
    @(negedge clk_i);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== 32'(value)) begin
      $error("threshold readback: expected %h, got %h", 32'(value), prdata);
      sb.mismatches++;
    end
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Pick a sample above or below the current threshold, hitting it exactly now and then
  function automatic logic [11:0] draw_sample(bit hit);
    logic [11:0] floor_v;
    floor_v = sb.thresh;
    if (hit || floor_v == 0) begin
      if ($urandom_range(0, 7) == 0) return floor_v;
      return 12'($urandom_range(floor_v, 4095));
    end
    return 12'($urandom_range(0, floor_v - 1));
  endfunction

  // Send channels of bunchy samples, with stray flushes, empty channels and unused commands
  task automatic run_channels(int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    bit          hit;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 40);
      hit = bit'($urandom_range(0, 1));
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 3) == 0) hit = !hit;
        if ($urandom_range(0, 19) == 0) begin
          send_request(CMD_UNUSED, 12'($urandom), 12'($urandom));
        end
        send_request(CMD_SAMPLE, draw_sample(hit), 12'($urandom));
        sent++;
        if ($urandom_range(0, 59) == 0) begin
          send_request(CMD_FLUSH, 12'($urandom), 12'($urandom));
          sent++;
        end
      end
      send_request(CMD_END_CHANNEL, 12'($urandom), 12'($urandom));
      sent++;
      if ($urandom_range(0, 4) == 0) begin
        send_request(CMD_FLUSH, 12'($urandom), 12'($urandom));
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    sb             = new();
    src_gap_pct    = 0;
    sink_stall_pct = 0;
    push           = 1'b0;
    command_i      = CMD_SAMPLE;
    adc_value_i    = '0;
    hw_address_i   = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    rst_ni         = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: threshold edge, saturation, bunch close, flushes, trailers, ignored fields
    write_threshold(12'h200);
    src_gap_pct    = 20;
    sink_stall_pct = 20;
    send_request(CMD_SAMPLE, 12'h200, 12'hFFF);
    send_request(CMD_SAMPLE, 12'hFFF, 12'h000);
    send_request(CMD_SAMPLE, 12'h3FF, 12'hABC);
    send_request(CMD_SAMPLE, 12'h1FF, 12'h000);
    send_request(CMD_SAMPLE, 12'h000, 12'hFFF);
    send_request(CMD_UNUSED, 12'hFFF, 12'hFFF);
    send_request(CMD_SAMPLE, 12'h400, 12'h555);
    send_request(CMD_FLUSH, 12'hABC, 12'h123);
    send_request(CMD_FLUSH, 12'hFFF, 12'hFFF);
    send_request(CMD_END_CHANNEL, 12'hFFF, 12'hFFF);
    send_request(CMD_END_CHANNEL, 12'h000, 12'h000);
    send_request(CMD_SAMPLE, 12'h1FF, 12'h000);
    send_request(CMD_END_CHANNEL, 12'h000, 12'h800);
    send_request(CMD_SAMPLE, 12'h201, 12'h000);
    send_request(CMD_SAMPLE, 12'h202, 12'h000);
    send_request(CMD_END_CHANNEL, 12'h3FF, 12'h555);
    send_request(CMD_SAMPLE, 12'hAAA, 12'h000);
    send_request(CMD_SAMPLE, 12'h555, 12'h000);
    send_request(CMD_END_CHANNEL, 12'h000, 12'h2AA);
    send_request(CMD_FLUSH, 12'h000, 12'h000);
    wait_for_quiet();

    // Random channels across threshold settings and idling mixes
    write_threshold(12'hFFF);
    run_channels(PHASE_ITEMS);
    wait_for_quiet();

    write_threshold(12'($urandom_range(0, 4095)));
    src_gap_pct    = 0;
    sink_stall_pct = 30;
    run_channels(PHASE_ITEMS);
    wait_for_quiet();

    // Zero threshold: every sample is kept
    write_threshold(12'h000);
    src_gap_pct    = 5;
    sink_stall_pct = 5;
    run_channels(PHASE_ITEMS);
    wait_for_quiet();

    write_threshold(12'h3FF);
    src_gap_pct    = 30;
    sink_stall_pct = 0;
    run_channels(PHASE_ITEMS);
    wait_for_quiet();

    write_threshold(12'h001);
    src_gap_pct    = 15;
    sink_stall_pct = 15;
    run_channels(PHASE_ITEMS);
    wait_for_quiet();

    // Finish at full rate on both sides
    write_threshold(12'($urandom_range(0, 4095)));
    src_gap_pct    = 0;
    sink_stall_pct = 0;
    run_channels(PHASE_ITEMS);
    wait_for_quiet();

    if (sb.mismatches == 0 && sb.pending_words.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/zsbp_pkg.sv
rtl/zsbp_front.sv
rtl/zsbp_queue.sv
rtl/zsbp_back.sv
rtl/zero_suppress_bunch_packer.sv
dv/tb.sv
